// File: rtl/pcl_pkg.sv
// pcl_pkg: shared types, sizes and codes for the per-source-address connection limiter.
// No dependencies; used by per_ip_connection_limiter_top.
package pcl_pkg;

   localparam int ADDR_ENTRIES = 64;
   localparam int CONN_SLOTS   = 256;

   localparam int IP_W       = 32;
   localparam int CONN_ID_W  = 8;
   localparam int CNT_W      = 9;
   localparam int VERDICT_W  = 3;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 9;

   localparam int SLOT_AW   = $clog2(CONN_SLOTS);
   localparam int IDX_EXT_W = (SLOT_AW > CONN_ID_W) ? SLOT_AW : CONN_ID_W;

   localparam logic [CNT_W-1:0] CNT_MAX = '1;

   localparam logic REQ_OPEN  = 1'b0;
   localparam logic REQ_CLOSE = 1'b1;

   typedef enum logic [VERDICT_W-1:0] {
      V_OK                 = 3'd0,
      V_TOO_MANY_USERS     = 3'd1,
      V_TOO_MANY_FROM_ADDR = 3'd2,
      V_TABLE_FULL         = 3'd3,
      V_UNKNOWN_SLOT       = 3'd4
   } verdict_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MAX_CLIENTS = 1'b0,
      CSR_MAX_PER_IP  = 1'b1
   } csr_index_type;

   typedef logic [ADDR_ENTRIES-1:0] entry_vec_type;

   function automatic logic [SLOT_AW-1:0] slot_idx(input logic [CONN_ID_W-1:0] id);
      logic [IDX_EXT_W-1:0] ext;
      ext = IDX_EXT_W'(id);
      return ext[SLOT_AW-1:0];
   endfunction

   function automatic logic slot_in_range(input logic [CONN_ID_W-1:0] id);
      return (IDX_EXT_W+1)'(id) < (IDX_EXT_W+1)'(CONN_SLOTS);
   endfunction

endpackage

// File: rtl/per_ip_connection_limiter_top.sv
// per_ip_connection_limiter_top: global and per-source-address connection limiter.
// Depends on pcl_pkg (sizes, verdict and register codes, slot index helpers).
//
//   channel   handshake            payload
//   request   start / busy         req_type, req_client_ip, req_conn_id
//   result    rsp_valid (strobe)   rsp_verdict, rsp_total_clients, rsp_ip_count
//   config    csr_we               csr_index, csr_wdata
//
// One request per cycle, no stalls. The accepting edge captures the request and
// reads the slot address RAM; in the next cycle the parallel address-table match
// and update run and the following edge loads the result register. A slot write
// from the request ahead is forwarded into the RAM read. busy is high only
// during reset.
// Reset clears the total count, valid bits and limits, not the RAM or entry counts.
module per_ip_connection_limiter_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic                              req_type,
   input  logic [pcl_pkg::IP_W-1:0]          req_client_ip,
   input  logic [pcl_pkg::CONN_ID_W-1:0]     req_conn_id,
   output logic                              rsp_valid,
   output logic [pcl_pkg::VERDICT_W-1:0]     rsp_verdict,
   output logic [pcl_pkg::CNT_W-1:0]         rsp_total_clients,
   output logic [pcl_pkg::CNT_W-1:0]         rsp_ip_count,
   input  logic                              csr_we,
   input  logic [pcl_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [pcl_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import pcl_pkg::*;

   logic accept;

   logic [CNT_W-1:0] max_clients_ff;
   logic [CNT_W-1:0] max_per_ip_ff;

   // stage 2 request registers
   logic                 stg_valid_ff;
   logic                 stg_type_ff;
   logic [IP_W-1:0]      stg_ip_ff;
   logic [SLOT_AW-1:0]   stg_idx_ff;
   logic                 stg_in_range_ff;

   // slot address RAM and forwarding
   logic [IP_W-1:0]      slot_mem [CONN_SLOTS];
   logic [IP_W-1:0]      slot_rd_ff;
   logic                 fwd_hit_ff;
   logic [IP_W-1:0]      fwd_data_ff;
   logic [CONN_SLOTS-1:0] slot_valid_ff;

   // address table
   logic [IP_W-1:0]      addr_key_ff [ADDR_ENTRIES];
   logic [CNT_W-1:0]     addr_cnt_ff [ADDR_ENTRIES];
   entry_vec_type        addr_valid_ff;
   entry_vec_type        addr_valid_in;
   logic [CNT_W-1:0]     total_ff;
   logic [CNT_W-1:0]     total_in;

   // result registers
   logic                 rsp_valid_ff;
   verdict_type          rsp_verdict_ff;
   verdict_type          rsp_verdict_in;
   logic [CNT_W-1:0]     rsp_total_ff;
   logic [CNT_W-1:0]     rsp_ipc_ff;
   logic [CNT_W-1:0]     rsp_ipc_in;

   logic [IP_W-1:0]      key;
   entry_vec_type        hit_vec;
   logic                 hit_any;
   logic [CNT_W-1:0]     hit_cnt;
   entry_vec_type        free_vec;
   entry_vec_type        free_oh;
   logic                 free_any;
   logic                 slot_ok;

   entry_vec_type        entry_we;
   logic                 alloc;
   logic [CNT_W-1:0]     cnt_new;
   logic                 slot_we;
   logic                 slot_clr;
   logic                 placed;

   assign busy   = reset;
   assign accept = start && !busy;

   // limits
   always_ff @(posedge clock) begin
      if (reset) begin
         max_clients_ff <= '0;
         max_per_ip_ff  <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_MAX_CLIENTS: max_clients_ff <= csr_wdata;
            CSR_MAX_PER_IP:  max_per_ip_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // stage 1: capture request, read slot RAM
   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff <= 1'b0;
      end else begin
         stg_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      stg_type_ff     <= req_type;
      stg_ip_ff       <= req_client_ip;
      stg_idx_ff      <= slot_idx(req_conn_id);
      stg_in_range_ff <= slot_in_range(req_conn_id);
      fwd_hit_ff      <= slot_we && (stg_idx_ff == slot_idx(req_conn_id));
      fwd_data_ff     <= stg_ip_ff;
   end

   always_ff @(posedge clock) begin
      if (slot_we) begin
         slot_mem[stg_idx_ff] <= stg_ip_ff;
      end
      slot_rd_ff <= slot_mem[slot_idx(req_conn_id)];
   end

   // stage 2: table match
   always_comb begin
      key = (stg_type_ff == REQ_OPEN) ? stg_ip_ff : (fwd_hit_ff ? fwd_data_ff : slot_rd_ff);
      hit_cnt = '0;
      for (int i = 0; i < ADDR_ENTRIES; i++) begin
         hit_vec[i] = addr_valid_ff[i] && (addr_key_ff[i] == key);
         hit_cnt    = hit_cnt | (hit_vec[i] ? addr_cnt_ff[i] : '0);
      end
      hit_any  = |hit_vec;
      free_vec = ~addr_valid_ff;
      free_oh  = free_vec & (~free_vec + ADDR_ENTRIES'(1));
      free_any = |free_vec;
      slot_ok  = stg_in_range_ff && slot_valid_ff[stg_idx_ff];
   end

   // stage 2: update and verdict
   always_comb begin
      addr_valid_in  = addr_valid_ff;
      total_in       = total_ff;
      entry_we       = '0;
      alloc          = 1'b0;
      cnt_new        = hit_cnt;
      slot_we        = 1'b0;
      slot_clr       = 1'b0;
      placed         = 1'b0;
      rsp_verdict_in = V_OK;
      rsp_ipc_in     = '0;
      if (stg_valid_ff) begin
         if (stg_type_ff == REQ_OPEN) begin
            if (hit_any) begin
               cnt_new  = (hit_cnt == CNT_MAX) ? hit_cnt : hit_cnt + CNT_W'(1);
               entry_we = hit_vec;
               placed   = 1'b1;
            end else if (free_any) begin
               cnt_new       = CNT_W'(1);
               entry_we      = free_oh;
               alloc         = 1'b1;
               addr_valid_in = addr_valid_ff | free_oh;
               placed        = 1'b1;
            end else begin
               rsp_verdict_in = V_TABLE_FULL;
            end
            if (placed) begin
               total_in   = (total_ff == CNT_MAX) ? total_ff : total_ff + CNT_W'(1);
               rsp_ipc_in = cnt_new;
               slot_we    = stg_in_range_ff;
               if ((max_clients_ff != '0) && (total_in > max_clients_ff)) begin
                  rsp_verdict_in = V_TOO_MANY_USERS;
               end else if ((max_per_ip_ff != '0) && (cnt_new > max_per_ip_ff)) begin
                  rsp_verdict_in = V_TOO_MANY_FROM_ADDR;
               end
            end
         end else begin
            total_in = (total_ff == '0) ? total_ff : total_ff - CNT_W'(1);
            if (slot_ok) begin
               slot_clr = 1'b1;
               if (hit_any) begin
                  cnt_new    = (hit_cnt == '0) ? hit_cnt : hit_cnt - CNT_W'(1);
                  entry_we   = hit_vec;
                  rsp_ipc_in = cnt_new;
                  if (cnt_new == '0) begin
                     addr_valid_in = addr_valid_ff & ~hit_vec;
                  end
               end
            end else begin
               rsp_verdict_in = V_UNKNOWN_SLOT;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_valid_ff <= '0;
         total_ff      <= '0;
         slot_valid_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         addr_valid_ff <= addr_valid_in;
         total_ff      <= total_in;
         rsp_valid_ff  <= stg_valid_ff;
         if (slot_we) begin
            slot_valid_ff[stg_idx_ff] <= 1'b1;
         end else if (slot_clr) begin
            slot_valid_ff[stg_idx_ff] <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < ADDR_ENTRIES; i++) begin
         if (entry_we[i]) begin
            addr_cnt_ff[i] <= cnt_new;
            if (alloc) begin
               addr_key_ff[i] <= stg_ip_ff;
            end
         end
      end
      if (stg_valid_ff) begin
         rsp_verdict_ff <= rsp_verdict_in;
         rsp_total_ff   <= total_in;
         rsp_ipc_ff     <= rsp_ipc_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_verdict       = rsp_verdict_ff;
   assign rsp_total_clients = rsp_total_ff;
   assign rsp_ip_count      = rsp_ipc_ff;

   // keys stay unique in the table; checked only when the key is meaningful
   a_unique_hit: assert property (@(posedge clock) disable iff (reset)
      (stg_valid_ff && ((stg_type_ff == REQ_OPEN) || slot_ok)) |-> $onehot0(hit_vec))
      else $error("address table holds duplicate keys");

   // every accepted request yields one result
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> ##1 rsp_valid)
      else $error("accepted request lost");

   // table full only when every entry is in use, with zero address count
   a_full_means_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_verdict == V_TABLE_FULL)) |-> ((&addr_valid_ff) && (rsp_ip_count == '0)))
      else $error("table full verdict with free entries");

   // counters move only while a request is in stage 2
   a_total_stable: assert property (@(posedge clock) disable iff (reset)
      !stg_valid_ff |=> $stable(total_ff))
      else $error("total count changed without a request");

endmodule

// File: dv/per_ip_connection_limiter_top_test.sv
// Self-checking testbench for per_ip_connection_limiter_top: directed table, then random phases.
// A built-in model of the counters, address table and slot map predicts every result not pinned by the directed table.
// Depends on pcl_pkg and the RTL top level only.
`timescale 1ns / 1ps

module per_ip_connection_limiter_top_test;
   import pcl_pkg::*;

   typedef struct packed {
      verdict_type          verdict;
      logic [CNT_W-1:0]     total_clients;
      logic [CNT_W-1:0]     ip_count;
   } conn_outcome_type;

   typedef struct packed {
      logic                 rtype;
      logic [IP_W-1:0]      ip;
      logic [CONN_ID_W-1:0] id;
      logic                 pinned;
      conn_outcome_type     want;
   } directed_row_type;

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   logic                  req_type;
   logic [IP_W-1:0]       req_client_ip;
   logic [CONN_ID_W-1:0]  req_conn_id;
   logic                  rsp_valid;
   logic [VERDICT_W-1:0]  rsp_verdict;
   logic [CNT_W-1:0]      rsp_total_clients;
   logic [CNT_W-1:0]      rsp_ip_count;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   per_ip_connection_limiter_top u_top (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_type          (req_type),
      .req_client_ip     (req_client_ip),
      .req_conn_id       (req_conn_id),
      .rsp_valid         (rsp_valid),
      .rsp_verdict       (rsp_verdict),
      .rsp_total_clients (rsp_total_clients),
      .rsp_ip_count      (rsp_ip_count),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   // limiter model state
   logic [CNT_W-1:0]      lim_clients;
   logic [CNT_W-1:0]      lim_per_ip;
   logic [CNT_W-1:0]      live_total;
   logic [IP_W-1:0]       ent_key   [ADDR_ENTRIES];
   logic [CNT_W-1:0]      ent_cnt   [ADDR_ENTRIES];
   logic                  ent_valid [ADDR_ENTRIES];
   logic [IP_W-1:0]       slot_ip   [CONN_SLOTS];
   logic                  slot_on   [CONN_SLOTS];

   conn_outcome_type      pending_outcomes [$];
   logic                  pin_on;
   conn_outcome_type      pin_outcome;
   int                    mismatches;
   int                    requests_seen;
   int                    results_checked;
   int                    settings_used;
   int                    verdict_seen [5];
   logic [CNT_W-1:0]      peak_total;

   directed_row_type directed_rows [18] = '{
      '{REQ_CLOSE, 32'hA5A5A5A5, 8'd5,   1'b1, '{V_UNKNOWN_SLOT,       9'd0, 9'd0}},
      '{REQ_OPEN,  32'h00000000, 8'd0,   1'b1, '{V_OK,                 9'd1, 9'd1}},
      '{REQ_OPEN,  32'hFFFFFFFF, 8'd255, 1'b1, '{V_OK,                 9'd2, 9'd1}},
      '{REQ_OPEN,  32'hFFFFFFFF, 8'd1,   1'b1, '{V_OK,                 9'd3, 9'd2}},
      '{REQ_OPEN,  32'hFFFFFFFF, 8'd2,   1'b1, '{V_TOO_MANY_USERS,     9'd4, 9'd3}},
      '{REQ_CLOSE, 32'h5A5A5A5A, 8'd0,   1'b1, '{V_OK,                 9'd3, 9'd0}},
      '{REQ_CLOSE, 32'hFFFFFFFF, 8'd2,   1'b1, '{V_OK,                 9'd2, 9'd2}},
      '{REQ_OPEN,  32'hFFFFFFFF, 8'd3,   1'b1, '{V_TOO_MANY_FROM_ADDR, 9'd3, 9'd3}},
      '{REQ_OPEN,  32'h12345678, 8'd255, 1'b0, '{V_OK,                 9'd0, 9'd0}},
      '{REQ_CLOSE, 32'h00000000, 8'd255, 1'b0, '{V_OK,                 9'd0, 9'd0}},
      '{REQ_CLOSE, 32'h00000000, 8'd255, 1'b0, '{V_OK,                 9'd0, 9'd0}},
      '{REQ_OPEN,  32'h80000000, 8'd128, 1'b0, '{V_OK,                 9'd0, 9'd0}},
      '{REQ_OPEN,  32'h7FFFFFFF, 8'd127, 1'b0, '{V_OK,                 9'd0, 9'd0}},
      '{REQ_CLOSE, 32'h0F0F0F0F, 8'd1,   1'b0, '{V_OK,                 9'd0, 9'd0}},
      '{REQ_CLOSE, 32'hF0F0F0F0, 8'd3,   1'b0, '{V_OK,                 9'd0, 9'd0}},
      '{REQ_CLOSE, 32'h00000000, 8'd128, 1'b0, '{V_OK,                 9'd0, 9'd0}},
      '{REQ_CLOSE, 32'h00000000, 8'd127, 1'b0, '{V_OK,                 9'd0, 9'd0}},
      '{REQ_CLOSE, 32'h00000000, 8'd200, 1'b0, '{V_OK,                 9'd0, 9'd0}}
   };

   initial clock = 1'b0;
   always #10 clock = ~clock;

   function automatic int find_entry(logic [IP_W-1:0] ip);
      for (int i = 0; i < ADDR_ENTRIES; i++)
         if (ent_valid[i] && ent_key[i] == ip) return i;
      return -1;
   endfunction

   function automatic int find_free_entry();
      for (int i = 0; i < ADDR_ENTRIES; i++)
         if (!ent_valid[i]) return i;
      return -1;
   endfunction

   function automatic void clear_limiter();
      lim_clients = '0;
      lim_per_ip  = '0;
      live_total  = '0;
      for (int i = 0; i < ADDR_ENTRIES; i++) begin
         ent_valid[i] = 1'b0;
         ent_cnt[i]   = '0;
      end
      for (int i = 0; i < CONN_SLOTS; i++) slot_on[i] = 1'b0;
   endfunction

   function automatic conn_outcome_type judge_event(logic rtype, logic [IP_W-1:0] ip,
                                                    logic [CONN_ID_W-1:0] id);
      conn_outcome_type o;
      int               e;
      o.verdict  = V_OK;
      o.ip_count = '0;
      if (rtype == REQ_OPEN) begin
         e = find_entry(ip);
         if (e < 0) begin
            e = find_free_entry();
            if (e < 0) begin
               o.verdict = V_TABLE_FULL;
            end else begin
               ent_valid[e] = 1'b1;
               ent_key[e]   = ip;
               ent_cnt[e]   = 9'd1;
            end
         end else if (ent_cnt[e] != CNT_MAX) begin
            ent_cnt[e] = ent_cnt[e] + 9'd1;
         end
         if (e >= 0) begin
            if (live_total != CNT_MAX) live_total = live_total + 9'd1;
            o.ip_count  = ent_cnt[e];
            slot_on[id] = 1'b1;
            slot_ip[id] = ip;
            if (lim_clients != 0 && live_total > lim_clients)
               o.verdict = V_TOO_MANY_USERS;
            else if (lim_per_ip != 0 && o.ip_count > lim_per_ip)
               o.verdict = V_TOO_MANY_FROM_ADDR;
         end
      end else begin
         if (live_total != 0) live_total = live_total - 9'd1;
         if (slot_on[id]) begin
            e = find_entry(slot_ip[id]);
            if (e >= 0) begin
               if (ent_cnt[e] != 0) ent_cnt[e] = ent_cnt[e] - 9'd1;
               o.ip_count = ent_cnt[e];
               if (ent_cnt[e] == 0) ent_valid[e] = 1'b0;
            end
            slot_on[id] = 1'b0;
         end else begin
            o.verdict = V_UNKNOWN_SLOT;
         end
      end
      o.total_clients = live_total;
      return o;
   endfunction

   // random slot that is live (want_on) or free; -1 if none
   function automatic int pick_slot(logic want_on);
      int base;
      base = $urandom_range(CONN_SLOTS - 1);
      for (int k = 0; k < CONN_SLOTS; k++)
         if (slot_on[(base + k) % CONN_SLOTS] == want_on) return (base + k) % CONN_SLOTS;
      return -1;
   endfunction

   function automatic logic [IP_W-1:0] known_or_fresh_ip();
      int base;
      base = $urandom_range(ADDR_ENTRIES - 1);
      for (int k = 0; k < ADDR_ENTRIES; k++)
         if (ent_valid[(base + k) % ADDR_ENTRIES]) return ent_key[(base + k) % ADDR_ENTRIES];
      return $urandom();
   endfunction

   always @(posedge clock) begin : scoreboard
      conn_outcome_type due;
      conn_outcome_type got;
      if (reset) begin
         clear_limiter();
      end else begin
         if (rsp_valid) begin
            if (pending_outcomes.size() == 0) begin
               $error("unexpected result: verdict %0d total %0d ip_count %0d",
                      rsp_verdict, rsp_total_clients, rsp_ip_count);
               mismatches++;
            end else begin
               due = pending_outcomes.pop_front();
               results_checked++;
               if (rsp_verdict !== due.verdict) begin
                  $error("verdict: expected %0d, got %0d", due.verdict, rsp_verdict);
                  mismatches++;
               end
               if (rsp_total_clients !== due.total_clients) begin
                  $error("total_clients: expected %0d, got %0d",
                         due.total_clients, rsp_total_clients);
                  mismatches++;
               end
               if (rsp_ip_count !== due.ip_count) begin
                  $error("ip_count: expected %0d, got %0d", due.ip_count, rsp_ip_count);
                  mismatches++;
               end
            end
         end
         if (csr_we) begin
            case (csr_index)
               CSR_MAX_CLIENTS: lim_clients = csr_wdata;
               CSR_MAX_PER_IP:  lim_per_ip  = csr_wdata;
               default: ;
            endcase
         end
         if (start && !busy) begin
            got = judge_event(req_type, req_client_ip, req_conn_id);
            if (pin_on) got = pin_outcome;
            pending_outcomes.push_back(got);
            requests_seen++;
            verdict_seen[got.verdict]++;
            if (got.total_clients > peak_total) peak_total = got.total_clients;
         end
      end
   end

   // all driving tasks start and end on a falling edge
   task automatic send_event(input logic rtype, input logic [IP_W-1:0] ip,
                             input logic [CONN_ID_W-1:0] id, input logic pinned,
                             input conn_outcome_type want);
      start         <= 1'b1;
      req_type      <= rtype;
      req_client_ip <= ip;
      req_conn_id   <= id;
      pin_on        <= pinned;
      pin_outcome   <= want;
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   task automatic hold_off(input int cycles);
      start <= 1'b0;
      repeat (cycles) @(negedge clock);
   endtask

   task automatic settle();
      start <= 1'b0;
      while (pending_outcomes.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic set_limits(input logic [CNT_W-1:0] mc, input logic [CNT_W-1:0] mp);
      csr_we    <= 1'b1;
      csr_index <= CSR_MAX_CLIENTS;
      csr_wdata <= mc;
      @(negedge clock);
      csr_index <= CSR_MAX_PER_IP;
      csr_wdata <= mp;
      @(negedge clock);
      csr_we    <= 1'b0;
      settings_used++;
   endtask

   task automatic run_phase(input int count, input logic [CNT_W-1:0] mc,
                            input logic [CNT_W-1:0] mp, input int open_pct,
                            input int pool_n, input int pool_pct, input int reuse_pct,
                            input int stray_pct, input int idle_pct);
      logic [IP_W-1:0]      pool [16];
      logic                 rtype;
      logic [IP_W-1:0]      ip;
      logic [CONN_ID_W-1:0] id;
      int                   s;
      conn_outcome_type     none;
      none = '0;
      settle();
      set_limits(mc, mp);
      pool[0] = known_or_fresh_ip();
      for (int k = 1; k < 16; k++) pool[k] = $urandom();
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(99) < idle_pct) hold_off($urandom_range(1, 4));
         if ($urandom_range(99) < open_pct) begin
            rtype = REQ_OPEN;
            ip    = ($urandom_range(99) < pool_pct) ? pool[$urandom_range(pool_n - 1)]
                                                    : $urandom();
            s     = pick_slot(1'b0);
            id    = (s < 0 || $urandom_range(99) < reuse_pct) ? CONN_ID_W'($urandom())
                                                              : CONN_ID_W'(s);
         end else begin
            rtype = REQ_CLOSE;
            ip    = $urandom();
            s     = pick_slot(1'b1);
            id    = (s < 0 || $urandom_range(99) < stray_pct) ? CONN_ID_W'($urandom())
                                                              : CONN_ID_W'(s);
         end
         send_event(rtype, ip, id, 1'b0, none);
      end
   endtask

   initial begin
      reset         = 1'b1;
      start         = 1'b0;
      req_type      = REQ_OPEN;
      req_client_ip = '0;
      req_conn_id   = '0;
      csr_we        = 1'b0;
      csr_index     = CSR_MAX_CLIENTS;
      csr_wdata     = '0;
      pin_on        = 1'b0;
      pin_outcome   = '0;
      mismatches    = 0;
      requests_seen = 0;
      results_checked = 0;
      settings_used = 0;
      peak_total    = '0;
      for (int v = 0; v < 5; v++) verdict_seen[v] = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      while (busy) @(negedge clock);

      set_limits(9'd3, 9'd2);
      foreach (directed_rows[r]) begin
         if ($urandom_range(99) < 30) hold_off($urandom_range(1, 4));
         send_event(directed_rows[r].rtype, directed_rows[r].ip, directed_rows[r].id,
                    directed_rows[r].pinned, directed_rows[r].want);
      end

      //        items  max_clients           max_per_ip            open pool %pool reuse stray idle
      run_phase(200, 9'd0,                 9'd0,                   55,  8,   80,   8,   15,  25);
      run_phase(140, 9'd256,               9'd256,                 85,  1,    0,   0,    0,  40);
      run_phase(140, 9'd1,                 9'd1,                   10,  4,  100,   0,   10,   0);
      run_phase(220, 9'($urandom_range(2, 40)), 9'($urandom_range(1, 8)),
                                                                   55, 16,   80,   8,   15,  30);
      run_phase(160, 9'd1,                 9'd1,                   50,  4,   90,   5,   20,  50);
      // one address until both counters pin at their ceiling
      run_phase(600, 9'd256,               9'($urandom_range(100, 256)),
                                                                   97,  1,  100,  30,    0,  20);
      run_phase(120, 9'($urandom_range(0, 256)), 9'($urandom_range(0, 256)),
                                                                   40,  8,   80,   8,   15,   0);
      settle();

      $display("Checked %0d results from %0d requests under %0d limit settings; peak total %0d",
               results_checked, requests_seen, settings_used, peak_total);
      $display("Verdicts ok/users/addr/full/unknown: %0d/%0d/%0d/%0d/%0d", verdict_seen[0],
               verdict_seen[1], verdict_seen[2], verdict_seen[3], verdict_seen[4]);
      if (mismatches == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("Test completed with failures");
      $finish;
   end

endmodule

// File: files.f
rtl/pcl_pkg.sv
rtl/per_ip_connection_limiter_top.sv
dv/per_ip_connection_limiter_top_test.sv
